[rtl/core/priority_resource_grant_top_defines.svh]
// Assertion macros used by the top RTL file of the resource grant block.
`ifndef PRIORITY_RESOURCE_GRANT_TOP_DEFINES_SVH
`define PRIORITY_RESOURCE_GRANT_TOP_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define PRG_ASSERT_NOW(lbl, clk, rst, trig, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// The condition must hold in the cycle after the trigger.
`define PRG_ASSERT_NEXT(lbl, clk, rst, trig, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

[rtl/core/prg_pkg.sv]
package prg_pkg;

   // Pool and queue sizes.
   localparam int MAX_RESOURCES = 8;
   localparam int QUEUE_DEPTH   = 16;

   // Field widths.
   localparam int ID_W     = 8;
   localparam int PRIO_W   = 4;
   localparam int STATUS_W = 3;
   localparam int RIDX_W   = $clog2(MAX_RESOURCES);
   localparam int RCNT_W   = 4;
   localparam int WCNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int QPTR_W   = $clog2(QUEUE_DEPTH);

   // Register port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam int REG_RESOURCES_IN_USE = 0;
   localparam logic [RCNT_W-1:0] RESOURCES_RESET = RCNT_W'(3);

   typedef enum logic [0:0] {
      OP_REQUEST = 1'b0,
      OP_RELEASE = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED = 3'd0,
      ST_QUEUED  = 3'd1,
      ST_FULL    = 3'd2,
      ST_FREED   = 3'd3,
      ST_HANDED  = 3'd4,
      ST_BAD     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_WAITQ,
      S_EMIT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      Q_IDLE,
      Q_SCAN,
      Q_PLACE,
      Q_POP
   } queue_state_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } queue_entry_type;

   typedef struct packed {
      logic              insert;
      logic              pop;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } queue_cmd_type;

   typedef struct packed {
      logic              done;
      logic [WCNT_W-1:0] count;
      logic [ID_W-1:0]   front_id;
   } queue_stat_type;

endpackage

[rtl/core/prg_req_if.sv]
interface prg_req_if;
   logic                        valid;
   logic                        ready;
   logic                        opcode;
   logic [prg_pkg::ID_W-1:0]    requester_id;
   logic [prg_pkg::PRIO_W-1:0]  request_priority;
   logic [prg_pkg::RIDX_W-1:0]  release_index;

   modport source (
      output valid, opcode, requester_id, request_priority, release_index,
      input  ready
   );
   modport sink (
      input  valid, opcode, requester_id, request_priority, release_index,
      output ready
   );
endinterface

[rtl/core/prg_rsp_if.sv]
interface prg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [prg_pkg::STATUS_W-1:0]  status;
   logic                          grant_valid;
   logic [prg_pkg::ID_W-1:0]      granted_id;
   logic [prg_pkg::RIDX_W-1:0]    granted_index;
   logic [prg_pkg::WCNT_W-1:0]    waiting_count;

   modport source (
      output valid, status, grant_valid, granted_id, granted_index, waiting_count,
      input  ready
   );
   modport sink (
      input  valid, status, grant_valid, granted_id, granted_index, waiting_count,
      output ready
   );
endinterface

[rtl/core/prg_csr.sv]
module prg_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [prg_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [prg_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [prg_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output logic [prg_pkg::RCNT_W-1:0]        resources_in_use
);

   logic [prg_pkg::RCNT_W-1:0]    ruse_ff;
   logic [prg_pkg::RCNT_W-1:0]    ruse_in;
   logic [prg_pkg::CSR_IDX_W-1:0] reg_idx;
   logic                          hit_ruse;

   // Word index of the access; byte offset bits are ignored.
   assign reg_idx  = csr_paddr[prg_pkg::CSR_ADDR_W-1:2];
   assign hit_ruse = (reg_idx == prg_pkg::CSR_IDX_W'(prg_pkg::REG_RESOURCES_IN_USE));

   // The port never inserts wait states.
   assign csr_pready = 1'b1;

   // Write in the access phase.
   always_comb begin
      ruse_in = ruse_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit_ruse) begin
         ruse_in = csr_pwdata[prg_pkg::RCNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ruse_ff <= prg_pkg::RESOURCES_RESET;
      end else begin
         ruse_ff <= ruse_in;
      end
   end

   // Read back; unmapped words read as zero.
   assign csr_prdata = hit_ruse ? prg_pkg::CSR_DATA_W'(ruse_ff) : '0;

   assign resources_in_use = ruse_ff;

endmodule

[rtl/core/prg_wait_queue.sv]
module prg_wait_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  prg_pkg::queue_cmd_type  q_cmd,
   output prg_pkg::queue_stat_type q_stat
);

   prg_pkg::queue_state_type   state_ff;
   prg_pkg::queue_state_type   state_in;
   logic [prg_pkg::QPTR_W-1:0] head_ff;
   logic [prg_pkg::QPTR_W-1:0] head_in;
   logic [prg_pkg::WCNT_W-1:0] count_ff;
   logic [prg_pkg::WCNT_W-1:0] count_in;
   logic [prg_pkg::QPTR_W-1:0] pos_ff;
   logic [prg_pkg::QPTR_W-1:0] pos_in;
   prg_pkg::queue_entry_type   new_ff;
   prg_pkg::queue_entry_type   new_in;
   prg_pkg::queue_entry_type   rd_data_ff;

   // Circular storage for the waiters, ordered from the head.
   prg_pkg::queue_entry_type   queue_mem_ff [prg_pkg::QUEUE_DEPTH];

   logic                       wr_en;
   logic [prg_pkg::QPTR_W-1:0] wr_addr;
   prg_pkg::queue_entry_type   wr_data;
   logic                       rd_en;
   logic [prg_pkg::QPTR_W-1:0] rd_addr;
   logic                       done;

   // Physical slot of a position counted from the head.
   function automatic logic [prg_pkg::QPTR_W-1:0] slot_of(
      input logic [prg_pkg::QPTR_W-1:0] head,
      input logic [prg_pkg::QPTR_W-1:0] offset
   );
      logic [prg_pkg::QPTR_W:0] sum;
      sum = {1'b0, head} + {1'b0, offset};
      if (sum >= (prg_pkg::QPTR_W + 1)'(prg_pkg::QUEUE_DEPTH)) begin
         sum = sum - (prg_pkg::QPTR_W + 1)'(prg_pkg::QUEUE_DEPTH);
      end
      return sum[prg_pkg::QPTR_W-1:0];
   endfunction

   // Sequencer: an insert walks the hole from the tail toward the head one
   // entry a cycle, moving every entry whose priority value is larger.
   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      new_in   = new_ff;
      wr_en    = 1'b0;
      wr_addr  = slot_of(head_ff, pos_ff);
      wr_data  = new_ff;
      rd_en    = 1'b0;
      rd_addr  = head_ff;
      done     = 1'b0;
      case (state_ff)
         prg_pkg::Q_IDLE: begin
            if (q_cmd.insert) begin
               new_in.id   = q_cmd.id;
               new_in.prio = q_cmd.prio;
               pos_in      = count_ff[prg_pkg::QPTR_W-1:0];
               if (count_ff == '0) begin
                  state_in = prg_pkg::Q_PLACE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = slot_of(head_ff,
                                     count_ff[prg_pkg::QPTR_W-1:0] - prg_pkg::QPTR_W'(1));
                  state_in = prg_pkg::Q_SCAN;
               end
            end else if (q_cmd.pop) begin
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               state_in = prg_pkg::Q_POP;
            end
         end
         prg_pkg::Q_SCAN: begin
            // The entry just ahead of the hole is in rd_data_ff.
            if (rd_data_ff.prio > new_ff.prio) begin
               wr_en   = 1'b1;
               wr_data = rd_data_ff;
               pos_in  = pos_ff - prg_pkg::QPTR_W'(1);
               if (pos_ff == prg_pkg::QPTR_W'(1)) begin
                  state_in = prg_pkg::Q_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = slot_of(head_ff, pos_ff - prg_pkg::QPTR_W'(2));
               end
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + prg_pkg::WCNT_W'(1);
               done     = 1'b1;
               state_in = prg_pkg::Q_IDLE;
            end
         end
         prg_pkg::Q_PLACE: begin
            wr_en    = 1'b1;
            count_in = count_ff + prg_pkg::WCNT_W'(1);
            done     = 1'b1;
            state_in = prg_pkg::Q_IDLE;
         end
         prg_pkg::Q_POP: begin
            // The front entry is in rd_data_ff.
            head_in  = slot_of(head_ff, prg_pkg::QPTR_W'(1));
            count_in = count_ff - prg_pkg::WCNT_W'(1);
            done     = 1'b1;
            state_in = prg_pkg::Q_IDLE;
         end
         default: begin
            state_in = prg_pkg::Q_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prg_pkg::Q_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Working position and the entry being inserted.
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      new_ff <= new_in;
   end

   // Storage with one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= queue_mem_ff[rd_addr];
      end
   end

   assign q_stat.done     = done;
   assign q_stat.count    = count_ff;
   assign q_stat.front_id = rd_data_ff.id;

endmodule

[rtl/core/priority_resource_grant_top.sv]
// Grants resources from a pool of up to eight, with a priority wait queue of
// sixteen entries. A request takes the lowest-numbered free resource below
// the resources_in_use register, else joins the queue behind every waiter of
// equal or smaller priority value, else is rejected when the queue is full.
// A release of a busy resource hands it straight to the front waiter, or
// frees it when nobody waits. One item is worked on at a time: it is accepted,
// decided on, waits on the wait queue when it inserts or hands over, and is
// then loaded into the result beat register once that register is free. A
// queue insertion walks one queue entry a cycle through the single read and
// write port of the wait-queue storage, moving every waiter it passes. A new
// request beat is taken as soon as the previous item has produced its result,
// even while that result beat still waits on the response side.
`include "priority_resource_grant_top_defines.svh"

module priority_resource_grant_top (
   input  logic                            clock,
   input  logic                            reset,
   prg_req_if.sink                         req_bus,
   prg_rsp_if.source                       rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [prg_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [prg_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [prg_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   logic [prg_pkg::RCNT_W-1:0]        resources_in_use;
   prg_pkg::queue_cmd_type            q_cmd;
   prg_pkg::queue_stat_type           q_stat;

   prg_pkg::ctrl_state_type           state_ff;
   prg_pkg::ctrl_state_type           state_in;
   logic [prg_pkg::MAX_RESOURCES-1:0] busy_ff;
   logic [prg_pkg::MAX_RESOURCES-1:0] busy_in;

   // Accepted item.
   prg_pkg::opcode_type               op_ff;
   prg_pkg::opcode_type               op_in;
   logic [prg_pkg::ID_W-1:0]          id_ff;
   logic [prg_pkg::ID_W-1:0]          id_in;
   logic [prg_pkg::PRIO_W-1:0]        prio_ff;
   logic [prg_pkg::PRIO_W-1:0]        prio_in;
   logic [prg_pkg::RIDX_W-1:0]        rel_ff;
   logic [prg_pkg::RIDX_W-1:0]        rel_in;

   // Pending result.
   prg_pkg::status_type               res_status_ff;
   prg_pkg::status_type               res_status_in;
   logic                              res_grant_ff;
   logic                              res_grant_in;
   logic [prg_pkg::ID_W-1:0]          res_id_ff;
   logic [prg_pkg::ID_W-1:0]          res_id_in;
   logic [prg_pkg::RIDX_W-1:0]        res_index_ff;
   logic [prg_pkg::RIDX_W-1:0]        res_index_in;

   // Output register.
   logic                              out_valid_ff;
   logic                              out_valid_in;
   prg_pkg::status_type               out_status_ff;
   prg_pkg::status_type               out_status_in;
   logic                              out_grant_ff;
   logic                              out_grant_in;
   logic [prg_pkg::ID_W-1:0]          out_id_ff;
   logic [prg_pkg::ID_W-1:0]          out_id_in;
   logic [prg_pkg::RIDX_W-1:0]        out_index_ff;
   logic [prg_pkg::RIDX_W-1:0]        out_index_in;
   logic [prg_pkg::WCNT_W-1:0]        out_wcount_ff;
   logic [prg_pkg::WCNT_W-1:0]        out_wcount_in;

   logic [prg_pkg::RCNT_W-1:0]        usable_n;
   logic [prg_pkg::MAX_RESOURCES-1:0] usable_mask;
   logic [prg_pkg::MAX_RESOURCES-1:0] free_vec;
   logic                              free_found;
   logic [prg_pkg::RIDX_W-1:0]        free_idx;
   logic                              rel_ok;
   logic                              q_full;

   prg_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .resources_in_use (resources_in_use)
   );

   prg_wait_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_cmd  (q_cmd),
      .q_stat (q_stat)
   );

   // Usable count is the register limited to the pool size.
   assign usable_n = (resources_in_use > prg_pkg::RCNT_W'(prg_pkg::MAX_RESOURCES)) ?
                     prg_pkg::RCNT_W'(prg_pkg::MAX_RESOURCES) : resources_in_use;

   // Lowest free usable resource.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = 0; i < prg_pkg::MAX_RESOURCES; i++) begin
         usable_mask[i] = (prg_pkg::RCNT_W'(i) < usable_n);
      end
      free_vec = usable_mask & ~busy_ff;
      for (int i = prg_pkg::MAX_RESOURCES - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            free_found = 1'b1;
            free_idx   = prg_pkg::RIDX_W'(i);
         end
      end
   end

   assign rel_ok = (prg_pkg::RCNT_W'(rel_ff) < usable_n) && busy_ff[rel_ff];
   assign q_full = (q_stat.count == prg_pkg::WCNT_W'(prg_pkg::QUEUE_DEPTH));

   // Sequencer: accept, decide, wait on the queue, hand the result over.
   always_comb begin
      state_in      = state_ff;
      busy_in       = busy_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      prio_in       = prio_ff;
      rel_in        = rel_ff;
      res_status_in = res_status_ff;
      res_grant_in  = res_grant_ff;
      res_id_in     = res_id_ff;
      res_index_in  = res_index_ff;
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      out_status_in = out_status_ff;
      out_grant_in  = out_grant_ff;
      out_id_in     = out_id_ff;
      out_index_in  = out_index_ff;
      out_wcount_in = out_wcount_ff;
      q_cmd.insert  = 1'b0;
      q_cmd.pop     = 1'b0;
      q_cmd.id      = id_ff;
      q_cmd.prio    = prio_ff;
      req_bus.ready = 1'b0;
      case (state_ff)
         prg_pkg::S_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               op_in    = prg_pkg::opcode_type'(req_bus.opcode);
               id_in    = req_bus.requester_id;
               prio_in  = req_bus.request_priority;
               rel_in   = req_bus.release_index;
               state_in = prg_pkg::S_EXEC;
            end
         end
         prg_pkg::S_EXEC: begin
            res_grant_in = 1'b0;
            res_id_in    = '0;
            res_index_in = '0;
            state_in     = prg_pkg::S_EMIT;
            if (op_ff == prg_pkg::OP_REQUEST) begin
               if (free_found) begin
                  busy_in[free_idx] = 1'b1;
                  res_status_in     = prg_pkg::ST_GRANTED;
                  res_grant_in      = 1'b1;
                  res_id_in         = id_ff;
                  res_index_in      = free_idx;
               end else if (q_full) begin
                  res_status_in = prg_pkg::ST_FULL;
               end else begin
                  q_cmd.insert  = 1'b1;
                  res_status_in = prg_pkg::ST_QUEUED;
                  state_in      = prg_pkg::S_WAITQ;
               end
            end else begin
               if (!rel_ok) begin
                  res_status_in = prg_pkg::ST_BAD;
               end else if (q_stat.count == '0) begin
                  busy_in[rel_ff] = 1'b0;
                  res_status_in   = prg_pkg::ST_FREED;
               end else begin
                  // Resource stays busy and passes to the front waiter.
                  q_cmd.pop     = 1'b1;
                  res_status_in = prg_pkg::ST_HANDED;
                  res_grant_in  = 1'b1;
                  res_index_in  = rel_ff;
                  state_in      = prg_pkg::S_WAITQ;
               end
            end
         end
         prg_pkg::S_WAITQ: begin
            if (q_stat.done) begin
               if (res_status_ff == prg_pkg::ST_HANDED) begin
                  res_id_in = q_stat.front_id;
               end
               state_in = prg_pkg::S_EMIT;
            end
         end
         prg_pkg::S_EMIT: begin
            if (!out_valid_ff || rsp_bus.ready) begin
               out_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_grant_in  = res_grant_ff;
               out_id_in     = res_id_ff;
               out_index_in  = res_index_ff;
               out_wcount_in = q_stat.count;
               state_in      = prg_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = prg_pkg::S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prg_pkg::S_IDLE;
         busy_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Item, pending result and result beat payload.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      prio_ff       <= prio_in;
      rel_ff        <= rel_in;
      res_status_ff <= res_status_in;
      res_grant_ff  <= res_grant_in;
      res_id_ff     <= res_id_in;
      res_index_ff  <= res_index_in;
      out_status_ff <= out_status_in;
      out_grant_ff  <= out_grant_in;
      out_id_ff     <= out_id_in;
      out_index_ff  <= out_index_in;
      out_wcount_ff <= out_wcount_in;
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.status        = out_status_ff;
   assign rsp_bus.grant_valid   = out_grant_ff;
   assign rsp_bus.granted_id    = out_id_ff;
   assign rsp_bus.granted_index = out_index_ff;
   assign rsp_bus.waiting_count = out_wcount_ff;

   // A grant only comes with a direct grant or a handover.
   `PRG_ASSERT_NOW(a_grant_status, clock, reset, rsp_bus.valid && rsp_bus.grant_valid, rsp_bus.status == prg_pkg::ST_GRANTED || rsp_bus.status == prg_pkg::ST_HANDED, "grant beat with a non-grant status")
   // The queue never holds more than its depth.
   `PRG_ASSERT_NOW(a_wait_bound, clock, reset, 1'b1, q_stat.count <= prg_pkg::WCNT_W'(prg_pkg::QUEUE_DEPTH), "wait queue over its depth")
   // The queue reports completion only to a waiting sequencer.
   `PRG_ASSERT_NOW(a_done_waitq, clock, reset, q_stat.done, state_ff == prg_pkg::S_WAITQ, "queue done outside of a queue wait")
   // The busy mask does not move while a queue operation runs.
   `PRG_ASSERT_NEXT(a_busy_hold, clock, reset, state_ff == prg_pkg::S_WAITQ, busy_ff == $past(busy_ff), "busy mask changed during a queue operation")

endmodule

[bench/prg_grant_checker.sv]
// Watches the request, result and register ports of the resource grant block.
// It keeps its own copy of the pool, the wait queue and the pool size, predicts
// one result for every accepted request beat and compares result beats in order.
module prg_grant_checker
   import prg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   prg_req_if                     req_mon,
   prg_rsp_if                     rsp_mon,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic                   csr_pready,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output int                     mismatches,
   output int                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      status_type         status;
      logic               grant_valid;
      logic [ID_W-1:0]    granted_id;
      logic [RIDX_W-1:0]  granted_index;
      logic [WCNT_W-1:0]  waiting_count;
   } grant_outcome_type;

   // Shadow state of the pool and the wait queue.
   logic [RCNT_W-1:0]         pool_size = RESOURCES_RESET;
   logic [MAX_RESOURCES-1:0]  busy_resources = '0;
   queue_entry_type           waiters [QUEUE_DEPTH];
   int                        waiter_count = 0;

   grant_outcome_type  expected_outcomes [$];
   int                 fail_total = 0;
   int                 pending_total = 0;
   int                 beats_seen = 0;

   assign mismatches  = fail_total;
   assign outstanding = pending_total;

   // Applies one request or release to the shadow state and returns the result
   // the block must produce for it.
   function automatic grant_outcome_type arbitrate(
      input logic               op,
      input logic [ID_W-1:0]    id,
      input logic [PRIO_W-1:0]  prio,
      input logic [RIDX_W-1:0]  rel
   );
      grant_outcome_type outcome;
      int usable;
      int slot;
      int i;
      bit placed;
      outcome = '{ST_BAD, 1'b0, '0, '0, '0};
      usable  = (int'(pool_size) > MAX_RESOURCES) ? MAX_RESOURCES : int'(pool_size);
      placed  = 1'b0;
      if (op == OP_REQUEST) begin
         // Lowest free usable resource wins, even with waiters queued.
         for (i = 0; i < usable; i++) begin
            if (!placed && !busy_resources[i]) begin
               busy_resources[i]     = 1'b1;
               outcome.status        = ST_GRANTED;
               outcome.grant_valid   = 1'b1;
               outcome.granted_id    = id;
               outcome.granted_index = RIDX_W'(i);
               placed                = 1'b1;
            end
         end
         if (!placed) begin
            if (waiter_count >= QUEUE_DEPTH) begin
               outcome.status = ST_FULL;
            end else begin
               // Insert behind every waiter of equal or smaller priority value.
               slot = waiter_count;
               while (slot > 0 && waiters[slot-1].prio > prio) begin
                  waiters[slot] = waiters[slot-1];
                  slot--;
               end
               waiters[slot] = '{id: id, prio: prio};
               waiter_count++;
               outcome.status = ST_QUEUED;
            end
         end
      end else begin
         if (int'(rel) >= usable || !busy_resources[rel]) begin
            outcome.status = ST_BAD;
         end else if (waiter_count == 0) begin
            busy_resources[rel] = 1'b0;
            outcome.status      = ST_FREED;
         end else begin
            // The resource stays busy and passes to the front waiter.
            outcome.granted_id = waiters[0].id;
            for (i = 0; i + 1 < waiter_count; i++) begin
               waiters[i] = waiters[i+1];
            end
            waiter_count--;
            outcome.status        = ST_HANDED;
            outcome.grant_valid   = 1'b1;
            outcome.granted_index = rel;
         end
      end
      outcome.waiting_count = WCNT_W'(waiter_count);
      return outcome;
   endfunction

   always @(posedge clock) begin
      grant_outcome_type wanted;
      if (reset) begin
         pool_size      = RESOURCES_RESET;
         busy_resources = '0;
         waiter_count   = 0;
         expected_outcomes.delete();
         pending_total  = 0;
      end else begin
         // Register writes must only happen while the block is idle; the block does not enforce it.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == CSR_ADDR_W'(4 * REG_RESOURCES_IN_USE)) begin
            pool_size = csr_pwdata[RCNT_W-1:0];
         end

         // Result beats are for items accepted earlier, so check them first.
         if (rsp_mon.valid && rsp_mon.ready) begin
            beats_seen++;
            if (expected_outcomes.size() == 0) begin
               fail_total++;
               if (fail_total <= REPORT_LIMIT) begin
                  $display("result beat %0d arrived with no request outstanding", beats_seen);
               end
            end else begin
               wanted = expected_outcomes.pop_front();
               if (rsp_mon.status        !== wanted.status        ||
                   rsp_mon.grant_valid   !== wanted.grant_valid   ||
                   rsp_mon.granted_id    !== wanted.granted_id    ||
                   rsp_mon.granted_index !== wanted.granted_index ||
                   rsp_mon.waiting_count !== wanted.waiting_count) begin
                  fail_total++;
                  if (fail_total <= REPORT_LIMIT) begin
                     $write("result beat %0d: expected status %0d grant %0b id %0d ",
                            beats_seen, wanted.status, wanted.grant_valid,
                            wanted.granted_id);
                     $write("index %0d waiting %0d, ",
                            wanted.granted_index, wanted.waiting_count);
                     $display("got status %0d grant %0b id %0d index %0d waiting %0d",
                              rsp_mon.status, rsp_mon.grant_valid, rsp_mon.granted_id,
                              rsp_mon.granted_index, rsp_mon.waiting_count);
                  end
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            expected_outcomes.push_back(arbitrate(req_mon.opcode, req_mon.requester_id,
                                                  req_mon.request_priority,
                                                  req_mon.release_index));
         end
         pending_total = expected_outcomes.size();
      end
   end

endmodule

[bench/tb_priority_resource_grant_top.sv]
// Drives request beats and register writes into the resource grant block and
// gives the verdict from the failure count of the checker beside it.
module tb_priority_resource_grant_top;
   timeunit 1ns;
   timeprecision 1ps;

   import prg_pkg::*;

   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 12;
   localparam int LIMIT_CYCLES    = 1_000_000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int PHASES          = 14;
   localparam int ITEMS_PER_PHASE = 135;
   localparam int QUIET_PHASES    = 3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   prg_req_if req_bus ();
   prg_rsp_if rsp_bus ();

   int   fail_count;
   int   pending_count;
   int   cycle_count = 0;
   logic req_took = 1'b0;
   bit   gaps_on = 1'b1;

   // Pool sizes per random phase: extremes, out-of-range values, shrink and grow.
   logic [RCNT_W-1:0] pool_plan [PHASES] =
      '{4'd1, 4'd8, 4'd2, 4'd0, 4'd5, 4'd15, 4'd3, 4'd9, 4'd4, 4'd1, 4'd7, 4'd6, 4'd8, 4'd2};

   priority_resource_grant_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   prg_grant_checker watcher (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .mismatches  (fail_count),
      .outstanding (pending_count)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Request acceptance as seen at the rising edge, read back at the falling one.
   always @(posedge clock) begin
      req_took <= req_bus.valid && req_bus.ready;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("priority_resource_grant_top: mismatch");
         $finish;
      end
   end

   // Result side stalls in random bursts while gaps are enabled.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   // Presents one request beat and returns at the falling edge after it is taken.
   task automatic send_beat(
      input opcode_type         op,
      input logic [ID_W-1:0]    id,
      input logic [PRIO_W-1:0]  prio,
      input logic [RIDX_W-1:0]  rel
   );
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.opcode           <= op;
      req_bus.requester_id     <= id;
      req_bus.request_priority <= prio;
      req_bus.release_index    <= rel;
      do @(negedge clock); while (!req_took);
   endtask

   // Stops sending and waits until every outstanding result has been taken.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   // Sets the pool size through a setup and an access cycle; upper data bits are noise.
   task automatic write_pool_size(input logic [RCNT_W-1:0] size);
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * REG_RESOURCES_IN_USE);
      csr_pwdata  <= {(CSR_DATA_W - RCNT_W)'($urandom), size};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin
      int phase;
      int n;
      int usable;
      int request_pct;
      opcode_type op;
      logic [RIDX_W-1:0] rel;

      req_bus.valid            = 1'b0;
      req_bus.opcode           = OP_REQUEST;
      req_bus.requester_id     = '0;
      req_bus.request_priority = '0;
      req_bus.release_index    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part with the pool size left at its reset value of three.
      // Fill the pool with extreme ids and priorities.
      send_beat(OP_REQUEST, 8'h00, 4'd0, 3'd7);
      send_beat(OP_REQUEST, 8'hFF, 4'd15, 3'd0);
      send_beat(OP_REQUEST, 8'hA5, 4'd7, 3'd5);
      // Queue with ties and an urgent request that jumps ahead.
      send_beat(OP_REQUEST, 8'h11, 4'd15, 3'd0);
      send_beat(OP_REQUEST, 8'h22, 4'd0, 3'd0);
      send_beat(OP_REQUEST, 8'h33, 4'd15, 3'd0);
      send_beat(OP_REQUEST, 8'h44, 4'd8, 3'd0);
      // Releases outside the usable range are rejected.
      send_beat(OP_RELEASE, 8'hFF, 4'd15, 3'd7);
      send_beat(OP_RELEASE, 8'h00, 4'd0, 3'd3);
      // Handovers drain the queue in priority order, ties first in first out.
      send_beat(OP_RELEASE, 8'h5A, 4'd3, 3'd1);
      send_beat(OP_RELEASE, 8'h00, 4'd0, 3'd2);
      send_beat(OP_RELEASE, 8'h00, 4'd0, 3'd0);
      send_beat(OP_RELEASE, 8'h00, 4'd0, 3'd0);
      // With nobody waiting the resource goes idle; a second release is bad.
      send_beat(OP_RELEASE, 8'h00, 4'd0, 3'd0);
      send_beat(OP_RELEASE, 8'h00, 4'd0, 3'd0);
      send_beat(OP_REQUEST, 8'h80, 4'd8, 3'd7);

      // Random phases: request-heavy and release-heavy stretches alternate so
      // that the queue swings between empty and full.
      for (phase = 0; phase < PHASES; phase++) begin
         write_pool_size(pool_plan[phase]);
         usable = (int'(pool_plan[phase]) > MAX_RESOURCES) ?
                  MAX_RESOURCES : int'(pool_plan[phase]);
         gaps_on = (phase < PHASES - QUIET_PHASES) && ($urandom_range(0, 3) != 0);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            request_pct = ((n / 24) % 2 == 0) ? 75 : 30;
            op = ($urandom_range(0, 99) < request_pct) ? OP_REQUEST : OP_RELEASE;
            if (usable > 0 && $urandom_range(0, 9) != 0) begin
               rel = RIDX_W'($urandom_range(0, usable - 1));
            end else begin
               rel = RIDX_W'($urandom_range(0, MAX_RESOURCES - 1));
            end
            send_beat(op, ID_W'($urandom_range(0, 255)), PRIO_W'($urandom_range(0, 15)), rel);
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("priority_resource_grant_top: match");
      end else begin
         $display("priority_resource_grant_top: mismatch");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/prg_pkg.sv
rtl/core/prg_req_if.sv
rtl/core/prg_rsp_if.sv
rtl/core/prg_csr.sv
rtl/core/prg_wait_queue.sv
rtl/core/priority_resource_grant_top.sv
bench/prg_grant_checker.sv
bench/tb_priority_resource_grant_top.sv
